// ===== design/c8wfd_pkg.sv =====
package c8wfd_pkg;

  localparam int unsigned MaxRes = 3;

  typedef logic [1:0] res_cnt_t;

  typedef enum logic [1:0] {
    OP_WORD = 2'd0,
    OP_CMD  = 2'd1,
    OP_RECV = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_HIGH = 3'b001,
    PH_LOW  = 3'b010,
    PH_CRC  = 3'b100
  } rx_phase_e;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_TX_WORD  = 3'd1,
    MODE_TX_CMD   = 3'd2,
    MODE_RX_PLAIN = 3'd3,
    MODE_RX_CHECK = 3'd4
  } mode_e;

  typedef enum logic {
    KIND_TX = 1'b0,
    KIND_RX = 1'b1
  } kind_e;

  typedef enum logic {
    REG_POLY = 1'b0,
    REG_INIT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] word;
    logic [7:0]  rx_byte;
    logic [7:0]  crc_mid;
    logic        crc_on;
    logic        eop;
  } s1_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic [15:0] rx_word;
    logic        crc_error;
    logic        last;
  } res_t;

  // One byte of an MSB-first CRC-8 with the top polynomial bit implied.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== design/crc8_word_framer_deframer_unit.sv =====
// Channel   Dir  Transfer when             Contents
// s_axis    in   s_axis_tvalid & tready    tdata: data_word, data_byte, first; tuser: op;
//                                          tlast: end_of_packet
// m_axis    out  m_axis_tvalid & tready    tdata: tx_byte, rx_word, crc_error; tuser: kind;
//                                          tlast: last
// cfg       in   cfg_we_i                  index 0 crc_poly, index 1 crc_init
//
// An item passes an input register, a CRC stage and a result register, in that order, before
// its first result is offered on m_axis, where it is held until m_axis_tready takes it.
// The result register emits one result per cycle while m_axis_tready is high: a sent word
// yields two or three results, a command byte or a completed received word one, and other received bytes none.
// A new item is taken every cycle while the result register keeps up.
// Reset clears the receive phase, the held word and the pipeline valids, and loads the
// registers with polynomial 0x31 and initial value 0xFF.
// A stall on m_axis holds the current result and fills the stages behind it before
// s_axis_tready drops.
module crc8_word_framer_deframer_unit import c8wfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] data_word, [23:16] data_byte, [24] first
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] tx_byte, [23:8] rx_word, [24] crc_error
  output logic        m_axis_tuser,  // [0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic [7:0]        poly_q;
  logic [7:0]        init_q;
  s1_t               s1;
  logic              s1_valid;
  logic              s1_ready;
  res_t [MaxRes-1:0] set;
  res_cnt_t          set_cnt;
  logic              set_valid;
  logic              set_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= 8'h31;
      init_q <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_POLY: poly_q <= cfg_wdata_i;
        REG_INIT: init_q <= cfg_wdata_i;
        default:  poly_q <= poly_q;
      endcase
    end
  end

  c8wfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .crc_poly_i    (poly_q),
    .crc_init_i    (init_q),
    .s1_o          (s1),
    .s1_valid_o    (s1_valid),
    .s1_ready_i    (s1_ready)
  );

  c8wfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_i        (s1),
    .s1_valid_i  (s1_valid),
    .s1_ready_o  (s1_ready),
    .crc_poly_i  (poly_q),
    .set_o       (set),
    .set_cnt_o   (set_cnt),
    .set_valid_o (set_valid),
    .set_ready_i (set_ready)
  );

  c8wfd_out_seq u_out_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .set_i         (set),
    .set_cnt_i     (set_cnt),
    .set_valid_i   (set_valid),
    .set_ready_o   (set_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== design/c8wfd_front.sv =====
module c8wfd_front import c8wfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic [7:0]  crc_poly_i,
  input  logic [7:0]  crc_init_i,
  output s1_t         s1_o,
  output logic        s1_valid_o,
  input  logic        s1_ready_i
);

  logic        in_valid_q;
  op_e         op_q;
  logic [15:0] word_q;
  logic [7:0]  byte_q;
  logic        first_q;
  logic        eop_q;

  rx_phase_e   phase_q, phase_d;
  rx_phase_e   eff_phase;
  logic [15:0] hold_q, hold_d;
  logic        crc_on;
  logic        fire;

  assign s_axis_tready = !in_valid_q || s1_ready_i;
  assign s1_valid_o    = in_valid_q;
  assign fire          = in_valid_q && s1_ready_i;
  assign crc_on        = |crc_poly_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= op_e'(s_axis_tuser);
      word_q  <= s_axis_tdata[15:0];
      byte_q  <= s_axis_tdata[23:16];
      first_q <= s_axis_tdata[24];
      eop_q   <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HIGH;
      hold_q  <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
    end
  end

  always_comb begin
    eff_phase = first_q ? PH_HIGH : phase_q;
    if (eff_phase == PH_CRC && !crc_on) begin
      eff_phase = PH_HIGH;
    end

    phase_d      = phase_q;
    hold_d       = hold_q;
    s1_o.mode    = MODE_NONE;
    s1_o.word    = word_q;
    s1_o.rx_byte = byte_q;
    s1_o.crc_on  = crc_on;
    s1_o.eop     = eop_q;

    unique case (op_q)
      OP_WORD: s1_o.mode = MODE_TX_WORD;
      OP_CMD:  s1_o.mode = MODE_TX_CMD;
      OP_RECV: begin
        unique case (eff_phase)
          PH_LOW: begin
            hold_d = {hold_q[15:8], byte_q};
            if (!crc_on) begin
              phase_d   = PH_HIGH;
              s1_o.mode = MODE_RX_PLAIN;
              s1_o.word = hold_d;
            end else begin
              phase_d = eop_q ? PH_HIGH : PH_CRC;
            end
          end
          PH_CRC: begin
            phase_d   = PH_HIGH;
            s1_o.mode = MODE_RX_CHECK;
            s1_o.word = hold_q;
          end
          default: begin
            hold_d  = {byte_q, 8'h00};
            phase_d = eop_q ? PH_HIGH : PH_LOW;
          end
        endcase
      end
      default: s1_o.mode = MODE_NONE;
    endcase

    s1_o.crc_mid = crc8_byte(crc_init_i, s1_o.word[15:8], crc_poly_i);
  end

  a_high_then_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && op_q == OP_RECV && first_q && !eop_q) |=> phase_q == PH_LOW)
    else $error("receive phase did not advance after a first high byte");

  a_check_resets_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_o.mode == MODE_RX_CHECK) |=> phase_q == PH_HIGH)
    else $error("receive phase not cleared after a CRC byte");

endmodule

// ===== design/c8wfd_back.sv =====
module c8wfd_back import c8wfd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  s1_t                    s1_i,
  input  logic                   s1_valid_i,
  output logic                   s1_ready_o,
  input  logic [7:0]             crc_poly_i,
  output res_t [MaxRes-1:0]      set_o,
  output res_cnt_t               set_cnt_o,
  output logic                   set_valid_o,
  input  logic                   set_ready_i
);

  logic       v_q;
  s1_t        s2_q;
  logic [7:0] crc_fin;

  function automatic res_t mk_tx(input logic [7:0] b, input logic l);
    res_t r;
    r.kind      = KIND_TX;
    r.tx_byte   = b;
    r.rx_word   = '0;
    r.crc_error = 1'b0;
    r.last      = l;
    return r;
  endfunction

  function automatic res_t mk_rx(input logic [15:0] w, input logic e, input logic l);
    res_t r;
    r.kind      = KIND_RX;
    r.tx_byte   = '0;
    r.rx_word   = w;
    r.crc_error = e;
    r.last      = l;
    return r;
  endfunction

  assign s1_ready_o  = !v_q || set_ready_i;
  assign set_valid_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (s1_ready_o) begin
      v_q <= s1_valid_i && (s1_i.mode != MODE_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_ready_o) begin
      s2_q <= s1_i;
    end
  end

  assign crc_fin = crc8_byte(s2_q.crc_mid, s2_q.word[7:0], crc_poly_i);

  always_comb begin
    set_o[0]  = mk_tx(8'h00, 1'b0);
    set_o[1]  = mk_tx(8'h00, 1'b0);
    set_o[2]  = mk_tx(8'h00, 1'b0);
    set_cnt_o = 2'd1;
    unique case (s2_q.mode)
      MODE_TX_WORD: begin
        set_o[0]  = mk_tx(s2_q.word[15:8], 1'b0);
        set_o[1]  = mk_tx(s2_q.word[7:0], s2_q.eop && !s2_q.crc_on);
        set_o[2]  = mk_tx(crc_fin, s2_q.eop);
        set_cnt_o = s2_q.crc_on ? 2'd3 : 2'd2;
      end
      MODE_TX_CMD:   set_o[0] = mk_tx(s2_q.rx_byte, s2_q.eop);
      MODE_RX_PLAIN: set_o[0] = mk_rx(s2_q.word, 1'b0, s2_q.eop);
      MODE_RX_CHECK: set_o[0] = mk_rx(s2_q.word, crc_fin != s2_q.rx_byte, s2_q.eop);
      default:       set_cnt_o = 2'd1;
    endcase
  end

endmodule

// ===== design/c8wfd_out_seq.sv =====
module c8wfd_out_seq import c8wfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  res_t [MaxRes-1:0] set_i,
  input  res_cnt_t          set_cnt_i,
  input  logic              set_valid_i,
  output logic              set_ready_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,
  output logic              m_axis_tuser,
  output logic              m_axis_tlast
);

  res_t [MaxRes-1:0] set_q;
  res_cnt_t          cnt_q;
  res_cnt_t          idx_q;
  res_t              cur;
  logic              xfer;
  logic              last_xfer;

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign xfer          = m_axis_tvalid && m_axis_tready;
  assign last_xfer     = xfer && (idx_q == cnt_q - 2'd1);
  assign set_ready_o   = (cnt_q == 2'd0) || last_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (set_valid_i && set_ready_o) begin
      cnt_q <= set_cnt_i;
      idx_q <= '0;
    end else if (last_xfer) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (xfer) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_valid_i && set_ready_o) begin
      set_q <= set_i;
    end
  end

  always_comb begin
    unique case (idx_q)
      2'd1:    cur = set_q[1];
      2'd2:    cur = set_q[2];
      default: cur = set_q[0];
    endcase
  end

  assign m_axis_tdata = {7'b0, cur.crc_error, cur.rx_word, cur.tx_byte};
  assign m_axis_tuser = cur.kind;
  assign m_axis_tlast = cur.last;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> idx_q < cnt_q)
    else $error("result index beyond the loaded count");

  a_no_gap_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !last_xfer) |=> m_axis_tvalid)
    else $error("gap inside a result set");

  a_rx_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && cur.kind == KIND_RX) |-> (cnt_q == 2'd1 && !cur.tx_byte[0]))
    else $error("received word not a single result");

endmodule

// ===== sim/c8wfd_frame_checker.sv =====
`timescale 1ns / 100ps

package c8wfd_tb_pkg;

  // Bit-serial form of the MSB-first CRC-8 over the high byte and then the low byte.
  function automatic logic [7:0] word_crc8(input logic [7:0] poly, input logic [7:0] seed,
                                           input logic [15:0] word);
    logic [7:0] acc;
    logic       fb;
    acc = seed;
    for (int i = 15; i >= 0; i--) begin
      fb  = acc[7] ^ word[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? poly : 8'h00);
    end
    return acc;
  endfunction

endpackage

module c8wfd_frame_checker
  import c8wfd_pkg::*;
  import c8wfd_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] data_word, [23:16] data_byte, [24] first
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // [7:0] tx_byte, [23:8] rx_word, [24] crc_error
  input  logic        m_axis_tuser,  // [0] kind
  input  logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  localparam logic [1:0] PhaseHigh = 2'd0;
  localparam logic [1:0] PhaseLow  = 2'd1;
  localparam logic [1:0] PhaseCrc  = 2'd2;
  localparam int         MaxReports = 10;

  logic [7:0]  poly_q;
  logic [7:0]  init_q;
  logic [1:0]  rx_phase_q;
  logic [15:0] rx_hold_q;
  res_t        bus_results_q[$];
  int          errors;

  task automatic queue_result(input kind_e kind, input logic [7:0] txb, input logic [15:0] rxw,
                              input logic err, input logic last);
    res_t r;
    r.kind      = kind;
    r.tx_byte   = txb;
    r.rx_word   = rxw;
    r.crc_error = err;
    r.last      = last;
    bus_results_q.push_back(r);
  endtask

  task automatic frame_step(input op_e op, input logic [15:0] word, input logic [7:0] data_byte,
                            input logic first, input logic eop);
    logic       crc_on;
    logic [1:0] ph;
    crc_on = (poly_q != 8'h00);
    case (op)
      OP_WORD: begin
        queue_result(KIND_TX, word[15:8], 16'h0000, 1'b0, 1'b0);
        if (crc_on) begin
          queue_result(KIND_TX, word[7:0], 16'h0000, 1'b0, 1'b0);
          queue_result(KIND_TX, word_crc8(poly_q, init_q, word), 16'h0000, 1'b0, eop);
        end else begin
          queue_result(KIND_TX, word[7:0], 16'h0000, 1'b0, eop);
        end
      end
      OP_CMD: begin
        queue_result(KIND_TX, data_byte, 16'h0000, 1'b0, eop);
      end
      OP_RECV: begin
        ph = first ? PhaseHigh : rx_phase_q;
        if (ph == PhaseCrc && !crc_on) begin
          ph = PhaseHigh;
        end
        if (ph == PhaseHigh) begin
          rx_hold_q  = {data_byte, 8'h00};
          rx_phase_q = eop ? PhaseHigh : PhaseLow;
        end else if (ph == PhaseLow) begin
          rx_hold_q[7:0] = data_byte;
          if (!crc_on) begin
            rx_phase_q = PhaseHigh;
            queue_result(KIND_RX, 8'h00, rx_hold_q, 1'b0, eop);
          end else begin
            rx_phase_q = eop ? PhaseHigh : PhaseCrc;
          end
        end else begin
          rx_phase_q = PhaseHigh;
          queue_result(KIND_RX, 8'h00, rx_hold_q,
                       word_crc8(poly_q, init_q, rx_hold_q) != data_byte, eop);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (bus_results_q.size() == 0) begin
      if (errors < MaxReports) begin
        $display("%0t: unexpected result kind=%0d tx_byte=%h rx_word=%h crc_error=%b last=%b",
                 $realtime, got.kind, got.tx_byte, got.rx_word, got.crc_error, got.last);
      end
      errors++;
    end else begin
      want = bus_results_q.pop_front();
      if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
          got.rx_word !== want.rx_word || got.crc_error !== want.crc_error ||
          got.last !== want.last) begin
        if (errors < MaxReports) begin
          $display("%0t: result mismatch expected kind=%0d tx_byte=%h rx_word=%h crc_error=%b last=%b",
                   $realtime, want.kind, want.tx_byte, want.rx_word, want.crc_error, want.last);
          $display("%0t:                 actual   kind=%0d tx_byte=%h rx_word=%h crc_error=%b last=%b",
                   $realtime, got.kind, got.tx_byte, got.rx_word, got.crc_error, got.last);
        end
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q     = 8'h31;
      init_q     = 8'hFF;
      rx_phase_q = PhaseHigh;
      rx_hold_q  = 16'h0000;
      bus_results_q.delete();
      errors     = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        frame_step(op_e'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[23:16],
                   s_axis_tdata[24], s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result('{kind: kind_e'(m_axis_tuser), tx_byte: m_axis_tdata[7:0],
                       rx_word: m_axis_tdata[23:8], crc_error: m_axis_tdata[24],
                       last: m_axis_tlast});
      end
      if (cfg_we_i) begin
        if (reg_idx_e'(cfg_idx_i) == REG_POLY) begin
          poly_q = cfg_wdata_i;
        end else begin
          init_q = cfg_wdata_i;
        end
      end
      mismatch_count_o <= errors;
      pending_o        <= bus_results_q.size();
    end
  end

endmodule

// ===== sim/crc8_word_framer_deframer_unit_tb.sv =====
`timescale 1ns / 100ps

module crc8_word_framer_deframer_unit_tb;
  import c8wfd_pkg::*;
  import c8wfd_tb_pkg::*;

  localparam int ResetCycles = 9;
  localparam int DrainCycles = 10;
  localparam int LongHold    = 150;
  localparam int CycleLimit  = 200000;
  localparam int PhaseItems  = 38;
  localparam int NumPhases   = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_wdata_i;

  int          mismatches;
  int          pending_results;
  int          items_sent;
  int          cycle_count;
  logic        send_gaps_on;
  logic        recv_stalls_on;
  logic        hold_req;
  logic [7:0]  cur_poly;
  logic [7:0]  cur_init;

  crc8_word_framer_deframer_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  c8wfd_frame_checker i_frame_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatches),
    .pending_o        (pending_results)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input op_e op, input logic [15:0] word, input logic [7:0] data_byte,
                           input logic first, input logic eop);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, first, data_byte, word};
    s_axis_tuser  <= op;
    s_axis_tlast  <= eop;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_POLY) begin
      cur_poly = value;
    end else begin
      cur_init = value;
    end
  endtask

  // A read of num_words words, each CRC byte (sent only with the CRC on) correct unless a bit of it is flipped.
  task automatic send_read_frame(input int num_words);
    logic [15:0] word;
    logic [7:0]  crc;
    logic        last_word;
    for (int w = 0; w < num_words; w++) begin
      word      = 16'($urandom);
      last_word = (w == num_words - 1);
      send_item(OP_RECV, 16'($urandom), word[15:8], w == 0, 1'b0);
      send_item(OP_RECV, 16'($urandom), word[7:0], 1'b0, cur_poly == 8'h00 && last_word);
      if (cur_poly != 8'h00) begin
        crc = word_crc8(cur_poly, cur_init, word);
        if ($urandom_range(0, 7) == 0) begin
          crc ^= 8'h01 << $urandom_range(0, 7);
        end
        send_item(OP_RECV, 16'($urandom), crc, 1'b0, last_word);
      end
    end
  endtask

  task automatic random_traffic(input int stop_at);
    int pick;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_item(OP_WORD, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 40) begin
        send_item(OP_CMD, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        send_read_frame($urandom_range(1, 3));
      end else begin
        send_item(op_e'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      stall = recv_stalls_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= OP_WORD;
    s_axis_tlast   <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= REG_POLY;
    cfg_wdata_i    <= 8'h00;
    items_sent     = 0;
    hold_req       = 1'b0;
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    cur_poly       = 8'h31;
    cur_init       = 8'hFF;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_WORD, 16'h0000, 8'h00, 1'b0, 1'b0);
    send_item(OP_WORD, 16'hFFFF, 8'h00, 1'b0, 1'b1);
    send_item(OP_CMD, 16'h0000, 8'h00, 1'b0, 1'b0);
    send_item(OP_CMD, 16'h0000, 8'hFF, 1'b0, 1'b1);
    send_item(OP_NONE, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
    send_item(OP_RECV, 16'h0000, 8'hBE, 1'b1, 1'b0);
    send_item(OP_RECV, 16'h0000, 8'hEF, 1'b0, 1'b0);
    send_item(OP_RECV, 16'h0000, word_crc8(cur_poly, cur_init, 16'hBEEF), 1'b0, 1'b0);
    send_item(OP_RECV, 16'h0000, 8'h12, 1'b0, 1'b0);
    send_item(OP_RECV, 16'h0000, 8'h34, 1'b0, 1'b0);
    send_item(OP_RECV, 16'h0000, word_crc8(cur_poly, cur_init, 16'h1234) ^ 8'h01, 1'b0, 1'b1);
    // End marks that fall on the high byte and on the low byte drop the partial word.
    send_item(OP_RECV, 16'h0000, 8'h55, 1'b0, 1'b1);
    send_item(OP_RECV, 16'h0000, 8'h66, 1'b0, 1'b0);
    send_item(OP_RECV, 16'h0000, 8'h77, 1'b0, 1'b1);
    send_item(OP_RECV, 16'h0000, 8'hAA, 1'b1, 1'b0);
    send_item(OP_RECV, 16'h0000, 8'hBB, 1'b1, 1'b0);
    send_item(OP_RECV, 16'h0000, 8'hCC, 1'b0, 1'b0);
    send_item(OP_RECV, 16'h0000, word_crc8(cur_poly, cur_init, 16'hBBCC), 1'b0, 1'b1);
    send_item(OP_RECV, 16'h0000, 8'h01, 1'b1, 1'b0);
    send_item(OP_WORD, 16'hA55A, 8'h00, 1'b0, 1'b0);
    send_item(OP_CMD, 16'h0000, 8'h3C, 1'b0, 1'b1);
    send_item(OP_RECV, 16'h0000, 8'h02, 1'b0, 1'b0);
    send_item(OP_RECV, 16'h0000, word_crc8(cur_poly, cur_init, 16'h0102), 1'b0, 1'b1);
    // Leave the receiver waiting for a CRC byte, then switch the CRC off.
    send_item(OP_RECV, 16'h0000, 8'h11, 1'b1, 1'b0);
    send_item(OP_RECV, 16'h0000, 8'h22, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_POLY, 8'h00);
    send_item(OP_RECV, 16'h0000, 8'h33, 1'b0, 1'b0);
    send_item(OP_RECV, 16'h0000, 8'h44, 1'b0, 1'b1);
    send_item(OP_WORD, 16'h1234, 8'h00, 1'b0, 1'b1);

    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(REG_POLY, 8'h31);
          write_reg(REG_INIT, 8'hFF);
        end
        1: begin
          write_reg(REG_POLY, 8'h07);
          write_reg(REG_INIT, 8'h00);
        end
        2: begin
          write_reg(REG_POLY, 8'h00);
          write_reg(REG_INIT, 8'($urandom));
        end
        3: begin
          write_reg(REG_POLY, 8'hFF);
          write_reg(REG_INIT, 8'hFF);
        end
        4: begin
          write_reg(REG_POLY, 8'h01);
          write_reg(REG_INIT, 8'h00);
        end
        default: begin
          write_reg(REG_POLY, 8'($urandom_range(1, 255)));
          write_reg(REG_INIT, 8'($urandom));
        end
      endcase
      send_gaps_on   = (phase != 0 && phase != 1);
      recv_stalls_on = (phase != 0);
      if (phase == 1) begin
        hold_req = 1'b1;
      end
      random_traffic(items_sent + PhaseItems);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== crc8_word_framer_deframer_unit.f =====
design/c8wfd_pkg.sv
design/c8wfd_front.sv
design/c8wfd_back.sv
design/c8wfd_out_seq.sv
design/crc8_word_framer_deframer_unit.sv
sim/c8wfd_frame_checker.sv
sim/crc8_word_framer_deframer_unit_tb.sv
